### hw/rtl/gsbb_pkg.sv
package gsbb_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned MaxRadius = 7;
  localparam int unsigned Lines     = 2 * MaxRadius + 1;

  localparam int unsigned PixW   = 8;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned RadW   = 3;
  localparam int unsigned CntW   = 4;
  localparam int unsigned AccW   = 12;
  localparam int unsigned RecipW = 17;
  localparam int unsigned FracW  = 16;
  localparam int unsigned ProdW  = AccW + RecipW;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 13;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWidth  = 2'd0,
    CfgHeight = 2'd1,
    CfgKernel = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    StIdle, StGrayB, StGrayG, StGrayR, StGrayMul, StGrayWr,
    StHSet, StHAcc, StHMul, StHWr, StCount,
    StVChk, StVRd, StVAdd, StVMul, StVOut
  } state_e;

  typedef struct packed {
    logic            clr;
    logic            add;
    logic            mul;
    logic [PixW-1:0] data;
  } avg_ctrl_t;

  // ceil(2^16 / d); exact truncating quotient for every dividend below 4096.
  function automatic logic [RecipW-1:0] recip(logic [CntW-1:0] d);
    logic [RecipW-1:0] m;
    case (d)
      4'd1:    m = 17'd65536;
      4'd2:    m = 17'd32768;
      4'd3:    m = 17'd21846;
      4'd4:    m = 17'd16384;
      4'd5:    m = 17'd13108;
      4'd6:    m = 17'd10923;
      4'd7:    m = 17'd9363;
      4'd8:    m = 17'd8192;
      4'd9:    m = 17'd7282;
      4'd10:   m = 17'd6554;
      4'd11:   m = 17'd5958;
      4'd12:   m = 17'd5462;
      4'd13:   m = 17'd5042;
      4'd14:   m = 17'd4682;
      4'd15:   m = 17'd4370;
      default: m = '0;
    endcase
    return m;
  endfunction

  // Steps a slot number back by k, modulo Lines.
  function automatic logic [SlotW-1:0] slot_back(logic [SlotW-1:0] s, logic [RadW-1:0] k);
    logic [SlotW-1:0] r;
    if (s >= SlotW'(k)) begin
      r = s - SlotW'(k);
    end else begin
      r = s + (SlotW'(Lines) - SlotW'(k));
    end
    return r;
  endfunction

  function automatic logic [SlotW-1:0] slot_next(logic [SlotW-1:0] s);
    logic [SlotW-1:0] r;
    if (s == SlotW'(Lines - 1)) begin
      r = '0;
    end else begin
      r = s + SlotW'(1);
    end
    return r;
  endfunction

endpackage

### hw/rtl/gsbb_ram.sv
module gsbb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/gsbb_avg.sv
module gsbb_avg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gsbb_pkg::avg_ctrl_t         ctrl_i,
  output logic [gsbb_pkg::PixW-1:0]   quot_o
);

  logic [gsbb_pkg::AccW-1:0]  acc_q, acc_d, acc_base;
  logic [gsbb_pkg::CntW-1:0]  cnt_q, cnt_d, cnt_base;
  logic [gsbb_pkg::ProdW-1:0] prod_q, prod_d;

  // Accumulate a window, then divide by its count with a reciprocal multiply.
  always_comb begin
    acc_base = ctrl_i.clr ? '0 : acc_q;
    cnt_base = ctrl_i.clr ? '0 : cnt_q;
    acc_d    = acc_base + (ctrl_i.add ? gsbb_pkg::AccW'(ctrl_i.data) : '0);
    cnt_d    = cnt_base + (ctrl_i.add ? gsbb_pkg::CntW'(1) : '0);
    prod_d   = gsbb_pkg::ProdW'(acc_q) * gsbb_pkg::ProdW'(gsbb_pkg::recip(cnt_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (ctrl_i.mul) begin
      prod_q <= prod_d;
    end
  end

  assign quot_o = prod_q[gsbb_pkg::FracW +: gsbb_pkg::PixW];

endmodule

### hw/rtl/gray_separable_box_blur_top.sv
// An accepted word has its gray value formed, then each finished row average (one, or up to
// R+1 at a row end), then, if a result is due, the column average; windows hold at most
// 2R+1 <= 15 values. With operation_i set or the input frame done, a word skips to the result check.
// Words are taken one at a time, each once the last is through (output stall included), set by the
// shared accumulate and reciprocal-multiply unit and the single read port of the line memory.
// Reset: asynchronous, active low; sets counters, state, output valid and config to their defaults.
module gray_separable_box_blur_top #(
  parameter int unsigned MAX_WIDTH  = gsbb_pkg::MaxWidth,
  parameter int unsigned MAX_HEIGHT = gsbb_pkg::MaxHeight
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gsbb_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [gsbb_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            operation_i,
  input  logic [7:0]                      blue_i,
  input  logic [7:0]                      green_i,
  input  logic [7:0]                      red_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      blurred_gray_o,
  output logic                            frame_last_o
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT);
  localparam int unsigned Depth = gsbb_pkg::Lines * MAX_WIDTH;
  localparam int unsigned AW    = $clog2(Depth);

  localparam int unsigned PixW  = gsbb_pkg::PixW;
  localparam int unsigned SlotW = gsbb_pkg::SlotW;
  localparam int unsigned RadW  = gsbb_pkg::RadW;
  localparam int unsigned CntW  = gsbb_pkg::CntW;

  // Configuration registers. Any write to one of the three registers restarts the frame.
  logic [10:0] image_width_q;
  logic [12:0] image_height_q;
  logic [3:0]  kernel_size_q;
  logic        cfg_hit;

  assign cfg_hit = cfg_we_i && (cfg_index_i == gsbb_pkg::CfgWidth ||
                                cfg_index_i == gsbb_pkg::CfgHeight ||
                                cfg_index_i == gsbb_pkg::CfgKernel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= 11'd1024;
      image_height_q <= 13'd1024;
      kernel_size_q  <= 4'd3;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gsbb_pkg::CfgWidth:  image_width_q  <= cfg_data_i[10:0];
        gsbb_pkg::CfgHeight: image_height_q <= cfg_data_i;
        gsbb_pkg::CfgKernel: kernel_size_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Frame geometry, saturated to the sizes the buffers hold. The radius is
  // half the kernel size and never exceeds the line buffer's reach.
  logic [CW-1:0]   w_last;
  logic [HW-1:0]   h_last;
  logic [RadW-1:0] rad;

  always_comb begin
    if (image_width_q == '0) begin
      w_last = '0;
    end else if (32'(image_width_q) > MAX_WIDTH) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(image_width_q - 11'd1);
    end
    if (image_height_q == '0) begin
      h_last = '0;
    end else if (32'(image_height_q) > MAX_HEIGHT) begin
      h_last = HW'(MAX_HEIGHT - 1);
    end else begin
      h_last = HW'(image_height_q - 13'd1);
    end
  end

  assign rad = kernel_size_q[3:1];

  // Sequencer state and position counters. Slots track row and column
  // positions modulo the number of buffered lines.
  gsbb_pkg::state_e state_q, state_d;

  logic [CW-1:0]    in_col_q, out_col_q, x_q, xhi_q;
  logic [HW-1:0]    in_row_q, out_row_q;
  logic [SlotW-1:0] in_cslot_q, in_rslot_q, out_rslot_q, xslot_q, slot_q;
  logic [CntW-1:0]  n_q;
  logic             in_done_q;
  logic [PixW-1:0]  blue_q, green_q, red_q;
  logic [PixW-1:0]  gwin_q [gsbb_pkg::Lines];

  logic [PixW-1:0]  out_gray_q;
  logic             out_last_q, out_valid_q;

  logic             in_accept, out_load, out_last;
  logic [PixW-1:0]  quot;
  gsbb_pkg::avg_ctrl_t avg_ctrl;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [PixW-1:0]  ram_rdata;

  // Window bounds for the row average at x_q and the column average at out_row_q.
  logic [RadW-1:0] c_back, x_back, x_fwd, y_back, y_fwd;
  logic [CW-1:0]   x_room;
  logic [HW-1:0]   y_room;
  logic [CW:0]     need_col_sum;
  logic [HW:0]     need_row_sum;
  logic [CW-1:0]   need_col;
  logic [HW-1:0]   need_row;
  logic            out_ready;

  always_comb begin
    c_back = (in_col_q < CW'(rad)) ? in_col_q[RadW-1:0] : rad;
    x_back = (x_q < CW'(rad)) ? x_q[RadW-1:0] : rad;
    x_room = w_last - x_q;
    x_fwd  = (x_room < CW'(rad)) ? x_room[RadW-1:0] : rad;
    y_back = (out_row_q < HW'(rad)) ? out_row_q[RadW-1:0] : rad;
    y_room = h_last - out_row_q;
    y_fwd  = (y_room < HW'(rad)) ? y_room[RadW-1:0] : rad;

    need_col_sum = {1'b0, out_col_q} + (CW+1)'(rad);
    need_row_sum = {1'b0, out_row_q} + (HW+1)'(rad);
    need_col = (need_col_sum > {1'b0, w_last}) ? w_last : need_col_sum[CW-1:0];
    need_row = (need_row_sum > {1'b0, h_last}) ? h_last : need_row_sum[HW-1:0];

    // A result is due once every row average in its window has been written.
    if (in_done_q) begin
      out_ready = 1'b1;
    end else if (in_row_q != need_row) begin
      out_ready = in_row_q > need_row;
    end else begin
      out_ready = in_col_q > need_col;
    end
  end

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_last  = (out_row_q == h_last) && (out_col_q == w_last);
  assign out_load  = (state_q == gsbb_pkg::StVOut) && (!out_valid_q || !out_stall_i);

  assign ram_waddr = AW'(32'(in_rslot_q) * MAX_WIDTH + 32'(x_q));
  assign ram_raddr = AW'(32'(slot_q) * MAX_WIDTH + 32'(out_col_q));

  // Next state and controls of the shared averaging unit.
  always_comb begin
    state_d    = state_q;
    avg_ctrl   = '0;
    ram_we     = 1'b0;
    in_stall_o = (state_q != gsbb_pkg::StIdle);
    case (state_q)
      gsbb_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = (!operation_i && !in_done_q) ? gsbb_pkg::StGrayB : gsbb_pkg::StVChk;
        end
      end
      gsbb_pkg::StGrayB: begin
        avg_ctrl.clr  = 1'b1;
        avg_ctrl.add  = 1'b1;
        avg_ctrl.data = blue_q;
        state_d       = gsbb_pkg::StGrayG;
      end
      gsbb_pkg::StGrayG: begin
        avg_ctrl.add  = 1'b1;
        avg_ctrl.data = green_q;
        state_d       = gsbb_pkg::StGrayR;
      end
      gsbb_pkg::StGrayR: begin
        avg_ctrl.add  = 1'b1;
        avg_ctrl.data = red_q;
        state_d       = gsbb_pkg::StGrayMul;
      end
      gsbb_pkg::StGrayMul: begin
        avg_ctrl.mul = 1'b1;
        state_d      = gsbb_pkg::StGrayWr;
      end
      gsbb_pkg::StGrayWr: begin
        // A row average is finished once its right edge is in, or at the row end.
        if (in_col_q == w_last || in_col_q >= CW'(rad)) begin
          state_d = gsbb_pkg::StHSet;
        end else begin
          state_d = gsbb_pkg::StCount;
        end
      end
      gsbb_pkg::StHSet: begin
        avg_ctrl.clr = 1'b1;
        state_d      = gsbb_pkg::StHAcc;
      end
      gsbb_pkg::StHAcc: begin
        avg_ctrl.add  = 1'b1;
        avg_ctrl.data = gwin_q[slot_q];
        if (n_q == CntW'(1)) begin
          state_d = gsbb_pkg::StHMul;
        end
      end
      gsbb_pkg::StHMul: begin
        avg_ctrl.mul = 1'b1;
        state_d      = gsbb_pkg::StHWr;
      end
      gsbb_pkg::StHWr: begin
        ram_we  = 1'b1;
        state_d = (x_q == xhi_q) ? gsbb_pkg::StCount : gsbb_pkg::StHSet;
      end
      gsbb_pkg::StCount: begin
        state_d = gsbb_pkg::StVChk;
      end
      gsbb_pkg::StVChk: begin
        if (out_ready) begin
          avg_ctrl.clr = 1'b1;
          state_d      = gsbb_pkg::StVRd;
        end else begin
          state_d = gsbb_pkg::StIdle;
        end
      end
      gsbb_pkg::StVRd: begin
        state_d = gsbb_pkg::StVAdd;
      end
      gsbb_pkg::StVAdd: begin
        avg_ctrl.add  = 1'b1;
        avg_ctrl.data = ram_rdata;
        state_d = (n_q == CntW'(1)) ? gsbb_pkg::StVMul : gsbb_pkg::StVRd;
      end
      gsbb_pkg::StVMul: begin
        avg_ctrl.mul = 1'b1;
        state_d      = gsbb_pkg::StVOut;
      end
      gsbb_pkg::StVOut: begin
        if (out_load) begin
          state_d = gsbb_pkg::StIdle;
        end
      end
      default: begin
        state_d = gsbb_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gsbb_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Position counters. A register write or the frame's last result restarts the frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q    <= '0;
      in_row_q    <= '0;
      in_cslot_q  <= '0;
      in_rslot_q  <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_rslot_q <= '0;
      in_done_q   <= 1'b0;
    end else if (cfg_hit || (out_load && out_last)) begin
      in_col_q    <= '0;
      in_row_q    <= '0;
      in_cslot_q  <= '0;
      in_rslot_q  <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_rslot_q <= '0;
      in_done_q   <= 1'b0;
    end else begin
      if (state_q == gsbb_pkg::StCount) begin
        if (in_col_q == w_last) begin
          in_col_q   <= '0;
          in_cslot_q <= '0;
          if (in_row_q == h_last) begin
            in_row_q   <= '0;
            in_rslot_q <= '0;
            in_done_q  <= 1'b1;
          end else begin
            in_row_q   <= in_row_q + HW'(1);
            in_rslot_q <= gsbb_pkg::slot_next(in_rslot_q);
          end
        end else begin
          in_col_q   <= in_col_q + CW'(1);
          in_cslot_q <= gsbb_pkg::slot_next(in_cslot_q);
        end
      end
      if (out_load) begin
        if (out_col_q == w_last) begin
          out_col_q   <= '0;
          out_row_q   <= out_row_q + HW'(1);
          out_rslot_q <= gsbb_pkg::slot_next(out_rslot_q);
        end else begin
          out_col_q <= out_col_q + CW'(1);
        end
      end
    end
  end

  // Window walkers and pixel holding registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      blue_q  <= blue_i;
      green_q <= green_i;
      red_q   <= red_i;
    end
    case (state_q)
      gsbb_pkg::StGrayWr: begin
        gwin_q[in_cslot_q] <= quot;
        x_q     <= in_col_q - CW'(c_back);
        xslot_q <= gsbb_pkg::slot_back(in_cslot_q, c_back);
        xhi_q   <= (in_col_q == w_last) ? in_col_q : in_col_q - CW'(c_back);
      end
      gsbb_pkg::StHSet: begin
        slot_q <= gsbb_pkg::slot_back(xslot_q, x_back);
        n_q    <= CntW'(x_back) + CntW'(x_fwd) + CntW'(1);
      end
      gsbb_pkg::StHAcc: begin
        slot_q <= gsbb_pkg::slot_next(slot_q);
        n_q    <= n_q - CntW'(1);
      end
      gsbb_pkg::StHWr: begin
        x_q     <= x_q + CW'(1);
        xslot_q <= gsbb_pkg::slot_next(xslot_q);
      end
      gsbb_pkg::StVChk: begin
        slot_q <= gsbb_pkg::slot_back(out_rslot_q, y_back);
        n_q    <= CntW'(y_back) + CntW'(y_fwd) + CntW'(1);
      end
      gsbb_pkg::StVAdd: begin
        slot_q <= gsbb_pkg::slot_next(slot_q);
        n_q    <= n_q - CntW'(1);
      end
      default: ;
    endcase
  end

  // Output register: holds a finished word while the next input word is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_gray_q <= quot;
      out_last_q <= out_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign blurred_gray_o = out_gray_q;
  assign frame_last_o   = out_last_q;

  gsbb_avg u_avg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (avg_ctrl),
    .quot_o (quot)
  );

  // Row-averaged lines, one slot per buffered row.
  gsbb_ram #(
    .Width (PixW),
    .Depth (Depth)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (quot),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

`ifndef NO_ASSERTIONS
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == gsbb_pkg::StVOut))
    else $error("output word appeared outside the output step");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_last) |=> (out_row_q == '0 && out_col_q == '0 && !in_done_q))
    else $error("frame did not restart after its last word");

  a_done_at_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_done_q |-> (in_col_q == '0 && in_row_q == '0))
    else $error("input counters moved after the frame was complete");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gsbb_pkg::StHAcc || state_q == gsbb_pkg::StVAdd) |-> n_q != '0)
    else $error("window walk with empty count");
`endif

endmodule
